FILE: src/ami_pkg.sv
// shared types, constants and sizes for the affine matrix inverse block
`timescale 1ns / 1ps

package ami_pkg;

  localparam int unsigned FracBitsDefault   = 16;
  localparam int unsigned QueueDepthDefault = 2;
  localparam int unsigned ThrW              = 16;
  localparam int unsigned CofW              = 64;
  localparam int unsigned DetW              = 98;
  localparam int unsigned QuotW             = 33;
  localparam int unsigned ElemCount         = 12;
  localparam int unsigned CofCount          = 9;

  typedef struct packed {
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a13;
    logic signed [31:0] trans_x;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
    logic signed [31:0] a23;
    logic signed [31:0] trans_y;
    logic signed [31:0] a31;
    logic signed [31:0] a32;
    logic signed [31:0] a33;
    logic signed [31:0] trans_z;
  } item_t;

  typedef struct packed {
    logic        [3:0]  element_index;
    logic signed [31:0] element_value;
    logic               singular;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [CofCount-1:0][CofW-1:0] cof;
    logic [DetW-1:0]               mag;
    logic                          dneg;
    logic                          sing;
    logic [2:0][31:0]              t;
  } job_t;

endpackage

FILE: src/affine_matrix_inverse_top.sv
// top level of the 3x4 affine matrix inverse block
//
// request channel: drive item_i with a row-major 3x4 matrix and raise push;
// the matrix is taken at a clock edge where push is high and full is low.
// result channel: while empty is low, result_o holds the oldest element;
// raise pop to take it. twelve elements follow every matrix, index 0 to 11,
// with last set on the twelfth and singular on all of them for a singular input.
// the front sequencer holds one matrix in a buffer and works out cofactors
// and determinant through one shared 33x33 multiplier; a job queue, two
// entries deep by default, then feeds the back part.
// the back part runs nine 33-step divisions on one shared divider, then the
// translation products, then the twelve results; a singular matrix skips the
// divisions and translation products and goes straight to its results.
// a stalled receiver stops the back part; the front and queue keep taking
// matrices until the queue and input buffer are full.
// reset clears the threshold to zero and empties every stage.
`timescale 1ns / 1ps

module affine_matrix_inverse_top #(
  parameter int unsigned FRAC_BITS   = ami_pkg::FracBitsDefault,
  parameter int unsigned QUEUE_DEPTH = ami_pkg::QueueDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  ami_pkg::item_t           item_i,
  output logic                     empty,
  input  logic                     pop,
  output ami_pkg::result_t         result_o,
  input  logic                     cfg_we_i,
  input  logic [ami_pkg::ThrW-1:0] cfg_wdata_i
);
  import ami_pkg::*;

  logic [ThrW-1:0] thr_q;
  logic            job_push, job_full, job_pop, job_empty;
  job_t            job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  ami_front #(
    .FracBits(FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .item_i    (item_i),
    .thr_i     (thr_q),
    .job_push_o(job_push),
    .job_full_i(job_full),
    .job_o     (job_in)
  );

  ami_fifo #(
    .Depth(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .full_o (job_full),
    .data_i (job_in),
    .pop_i  (job_pop),
    .empty_o(job_empty),
    .data_o (job_out)
  );

  ami_back #(
    .FracBits(FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_pop_o  (job_pop),
    .job_i      (job_out),
    .empty_o    (empty),
    .pop_i      (pop),
    .result_o   (result_o)
  );

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !result_o.last) |=>
      (!empty && result_o.element_index == 4'($past(result_o.element_index) + 1'b1)))
    else $error("result index did not advance by one");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.singular) |-> (result_o.element_value == '0))
    else $error("singular result with nonzero value");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.element_index <= 4'(ElemCount - 1)))
    else $error("result index out of range");

  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && result_o.last) |=> (empty || result_o.element_index == '0))
    else $error("new run did not start at index zero");

endmodule

FILE: src/ami_fifo.sv
// short job queue between the front and back parts
`timescale 1ns / 1ps

module ami_fifo #(
  parameter int unsigned Depth = ami_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  ami_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          empty_o,
  output ami_pkg::job_t data_o
);
  import ami_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: src/ami_front.sv
// front part: request buffer, cofactor and determinant sequencer, singular test
`timescale 1ns / 1ps

module ami_front #(
  parameter int unsigned FracBits = ami_pkg::FracBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  ami_pkg::item_t           item_i,
  input  logic [ami_pkg::ThrW-1:0] thr_i,
  output logic                     job_push_o,
  input  logic                     job_full_i,
  output ami_pkg::job_t            job_o
);
  import ami_pkg::*;

  localparam int unsigned CofSteps = 2 * CofCount;
  localparam int unsigned MulSteps = CofSteps + 6;
  localparam int unsigned LastStep = MulSteps + 1;

  // operand pairs: even step is the first product, odd step the subtracted one
  localparam logic [3:0] OpL [CofSteps] = '{
    4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
    4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
  localparam logic [3:0] OpR [CofSteps] = '{
    4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
    4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

  item_t                   buf_q;
  logic                    buf_valid_q;
  logic                    busy_q;
  logic [4:0]              step_q;
  logic signed [31:0]      a_q   [CofCount];
  logic signed [31:0]      t_q   [3];
  logic signed [CofW-1:0]  cof_q [CofCount];
  logic signed [DetW-1:0]  det_q;
  logic signed [32:0]      op_a, op_b;
  logic signed [65:0]      prod, prod_q;
  logic [4:0]              pstep_q;
  logic                    pvalid_q;
  logic                    load, accept, done;
  logic [4:0]              dstep, pdstep;
  logic [3:0]              dcof;
  logic [DetW-1:0]         mag, lim;

  assign load    = buf_valid_q & ~busy_q;
  assign full_o  = buf_valid_q & ~load;
  assign accept  = push_i & ~full_o;
  assign done    = busy_q & (step_q == 5'(LastStep)) & ~job_full_i;

  assign dstep   = step_q - 5'(CofSteps);
  assign pdstep  = pstep_q - 5'(CofSteps);
  assign dcof    = {1'b0, dstep[2:1], 1'b0} + {2'b00, dstep[2:1]};

  always_comb begin
    if (step_q < 5'(CofSteps)) begin
      op_a = 33'(a_q[OpL[step_q]]);
      op_b = 33'(a_q[OpR[step_q]]);
    end else begin
      op_a = 33'(a_q[{2'b00, dstep[2:1]}]);
      if (!dstep[0]) begin
        op_b = $signed({1'b0, cof_q[dcof][31:0]});
      end else begin
        op_b = $signed({cof_q[dcof][CofW-1], cof_q[dcof][CofW-1:32]});
      end
    end
    prod = op_a * op_b;
  end

  assign mag = det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);
  assign lim = DetW'(thr_i) << (2 * FracBits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      step_q      <= '0;
      pvalid_q    <= 1'b0;
    end else begin
      buf_valid_q <= accept | (buf_valid_q & ~load);
      pvalid_q    <= busy_q & (step_q < 5'(MulSteps));
      if (load) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (busy_q && step_q != 5'(LastStep)) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q <= item_i;
    end
    prod_q  <= prod;
    pstep_q <= step_q;
    if (load) begin
      a_q[0] <= buf_q.a11;
      a_q[1] <= buf_q.a12;
      a_q[2] <= buf_q.a13;
      a_q[3] <= buf_q.a21;
      a_q[4] <= buf_q.a22;
      a_q[5] <= buf_q.a23;
      a_q[6] <= buf_q.a31;
      a_q[7] <= buf_q.a32;
      a_q[8] <= buf_q.a33;
      t_q[0] <= buf_q.trans_x;
      t_q[1] <= buf_q.trans_y;
      t_q[2] <= buf_q.trans_z;
      det_q  <= '0;
    end else if (pvalid_q) begin
      if (pstep_q < 5'(CofSteps)) begin
        if (!pstep_q[0]) begin
          cof_q[pstep_q[4:1]] <= prod_q[CofW-1:0];
        end else begin
          cof_q[pstep_q[4:1]] <= cof_q[pstep_q[4:1]] - prod_q[CofW-1:0];
        end
      end else if (!pdstep[0]) begin
        det_q <= det_q + DetW'(prod_q);
      end else begin
        det_q <= det_q + (DetW'(prod_q) <<< 32);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CofCount; i++) begin
      job_o.cof[i] = cof_q[i];
    end
    job_o.mag  = mag;
    job_o.dneg = det_q[DetW-1];
    job_o.sing = (lim >= mag);
    job_o.t[0] = t_q[0];
    job_o.t[1] = t_q[1];
    job_o.t[2] = t_q[2];
  end

  assign job_push_o = busy_q & (step_q == 5'(LastStep));

endmodule

FILE: src/ami_div.sv
// radix-2 restoring divider giving a 33-bit quotient and an overflow flag
`timescale 1ns / 1ps

module ami_div #(
  parameter int unsigned NumW = 64 + 2 * ami_pkg::FracBitsDefault,
  parameter int unsigned DenW = ami_pkg::DetW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [NumW-1:0]            num_i,
  input  logic [DenW-1:0]            den_i,
  output logic                       done_o,
  output logic [ami_pkg::QuotW-1:0]  quot_o,
  output logic                       ovf_o
);
  import ami_pkg::*;

  localparam int unsigned CmpW = (NumW > DenW + QuotW) ? NumW + 1 : DenW + QuotW + 1;
  localparam int unsigned CntW = $clog2(QuotW);

  logic              busy_q, done_q, ovf_q;
  logic [CntW-1:0]   cnt_q;
  logic [DenW-1:0]   rem_q, den_q;
  logic [QuotW-1:0]  low_q, quot_q;
  logic [DenW:0]     trial, diff;
  logic              qbit;
  logic [CmpW-1:0]   num_ext;

  assign num_ext = CmpW'(num_i);
  assign trial   = {rem_q, low_q[QuotW-1]};
  assign diff    = trial - {1'b0, den_q};
  assign qbit    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QuotW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      ovf_q  <= (num_ext >= (CmpW'(den_i) << QuotW));
      rem_q  <= DenW'(num_ext >> QuotW);
      low_q  <= num_i[QuotW-1:0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      if (qbit) begin
        rem_q <= diff[DenW-1:0];
      end else begin
        rem_q <= trial[DenW-1:0];
      end
      quot_q <= {quot_q[QuotW-2:0], qbit};
      low_q  <= {low_q[QuotW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

endmodule

FILE: src/ami_back.sv
// back part: element divisions, translation column and result sequencing
`timescale 1ns / 1ps

module ami_back #(
  parameter int unsigned FracBits = ami_pkg::FracBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_empty_i,
  output logic             job_pop_o,
  input  ami_pkg::job_t    job_i,
  output logic             empty_o,
  input  logic             pop_i,
  output ami_pkg::result_t result_o
);
  import ami_pkg::*;

  localparam int unsigned NumW = CofW + 2 * FracBits;

  typedef enum logic [3:0] {
    SIdle  = 4'b0001,
    SDiv   = 4'b0010,
    STrans = 4'b0100,
    SEmit  = 4'b1000
  } back_state_e;

  localparam logic [3:0] ElemPos [CofCount] = '{
    4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10};

  back_state_e         state_q;
  job_t                job_q;
  logic [3:0]          e_q, idx_q, inv_idx;
  logic                launched_q, tph_q;
  logic [1:0]          tr_q, tc_q;
  logic signed [31:0]  inv_q [CofCount];
  logic [31:0]         val_q [ElemCount];
  logic signed [63:0]  tprod_q;
  logic signed [65:0]  acc_q, sum;
  logic signed [66:0]  nsum, shr;
  logic [31:0]         tval, dval;
  logic [CofW-1:0]     cofsel, cabs;
  logic                cneg, qneg;
  logic                div_start, div_done, div_ovf;
  logic [QuotW-1:0]    div_quot;
  logic [NumW-1:0]     num;

  assign cofsel    = job_q.cof[e_q];
  assign cneg      = cofsel[CofW-1];
  assign cabs      = cneg ? (CofW'(0) - cofsel) : cofsel;
  assign num       = NumW'(cabs) << (2 * FracBits);
  assign div_start = (state_q == SDiv) & ~launched_q;
  assign qneg      = cneg ^ job_q.dneg;

  ami_div #(
    .NumW(NumW),
    .DenW(DetW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (job_q.mag),
    .done_o (div_done),
    .quot_o (div_quot),
    .ovf_o  (div_ovf)
  );

  always_comb begin
    if (qneg) begin
      if (div_ovf || div_quot > QuotW'(33'h080000000)) begin
        dval = 32'h80000000;
      end else begin
        dval = 32'(0) - div_quot[31:0];
      end
    end else if (div_ovf || div_quot[32] || div_quot[31]) begin
      dval = 32'h7fffffff;
    end else begin
      dval = div_quot[31:0];
    end
  end

  assign inv_idx = {1'b0, tr_q, 1'b0} + {2'b00, tr_q} + {2'b00, tc_q};
  assign sum     = acc_q + 66'(tprod_q);
  assign nsum    = -(67'(sum));
  assign shr     = nsum >>> FracBits;

  always_comb begin
    if (shr[66:31] == '0 || shr[66:31] == '1) begin
      tval = shr[31:0];
    end else if (shr[66]) begin
      tval = 32'h80000000;
    end else begin
      tval = 32'h7fffffff;
    end
  end

  assign job_pop_o = (state_q == SIdle) & ~job_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      e_q        <= '0;
      idx_q      <= '0;
      launched_q <= 1'b0;
      tph_q      <= 1'b0;
      tr_q       <= '0;
      tc_q       <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          if (!job_empty_i) begin
            e_q        <= '0;
            idx_q      <= '0;
            launched_q <= 1'b0;
            state_q    <= job_i.sing ? SEmit : SDiv;
          end
        end
        SDiv: begin
          if (div_start) begin
            launched_q <= 1'b1;
          end else if (div_done) begin
            launched_q <= 1'b0;
            if (e_q == 4'(CofCount - 1)) begin
              tr_q    <= '0;
              tc_q    <= '0;
              tph_q   <= 1'b0;
              state_q <= STrans;
            end else begin
              e_q <= e_q + 1'b1;
            end
          end
        end
        STrans: begin
          tph_q <= ~tph_q;
          if (tph_q) begin
            if (tc_q == 2'd2) begin
              tc_q <= '0;
              if (tr_q == 2'd2) begin
                idx_q   <= '0;
                state_q <= SEmit;
              end else begin
                tr_q <= tr_q + 1'b1;
              end
            end else begin
              tc_q <= tc_q + 1'b1;
            end
          end
        end
        SEmit: begin
          if (pop_i) begin
            if (idx_q == 4'(ElemCount - 1)) begin
              state_q <= SIdle;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
      if (job_i.sing) begin
        for (int i = 0; i < ElemCount; i++) begin
          val_q[i] <= '0;
        end
      end
      acc_q <= '0;
    end
    if (state_q == SDiv && div_done) begin
      inv_q[e_q]          <= dval;
      val_q[ElemPos[e_q]] <= dval;
    end
    if (state_q == STrans) begin
      if (!tph_q) begin
        tprod_q <= inv_q[inv_idx] * $signed(job_q.t[tc_q]);
      end else if (tc_q == 2'd2) begin
        val_q[{tr_q, 2'b11}] <= tval;
        acc_q                <= '0;
      end else begin
        acc_q <= sum;
      end
    end
  end

  assign empty_o                = (state_q != SEmit);
  assign result_o.element_index = idx_q;
  assign result_o.element_value = val_q[idx_q];
  assign result_o.singular      = job_q.sing;
  assign result_o.last          = (idx_q == 4'(ElemCount - 1));

endmodule
